FILE: sv/bdq_pkg.sv
`timescale 1ns / 1ps

package bdq_pkg;

    localparam int DEPTH_DEF      = 128;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int CMD_W    = 4;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 8;
    localparam int COUNT_W  = 8;
    localparam int STATUS_W = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 4'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 4'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 4'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 4'd3;
    localparam logic [CMD_W-1:0] CMD_INSERT     = 4'd4;
    localparam logic [CMD_W-1:0] CMD_ERASE      = 4'd5;
    localparam logic [CMD_W-1:0] CMD_READ_AT    = 4'd6;
    localparam logic [CMD_W-1:0] CMD_FRONT      = 4'd7;
    localparam logic [CMD_W-1:0] CMD_BACK       = 4'd8;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 4'd9;
    localparam logic [CMD_W-1:0] CMD_RESIZE     = 4'd10;
    localparam logic [CMD_W-1:0] CMD_ASSIGN     = 4'd11;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    typedef enum logic [1:0] {
        WALK_UP,
        WALK_DOWN,
        WALK_FILL
    } walk_mode_t;

    typedef struct packed {
        logic       go;
        walk_mode_t mode;
    } walk_cmd_t;

endpackage

FILE: sv/bounded_array_deque.sv
// Bounded array deque: one command word in, one result word out.
// Steps: read_at, front and back pass through the read, capture and result states;
// pop_back, clear, shrinking resize and failed commands go straight to the result
// state; fills and shifts run the walker first, and push or insert then drop the new
// word in through the insert-write state; one entry per walker cycle.
// Throughput: one command at a time; input stall is high until the result is registered.
// Reset clears the count and the control state; entry storage is not cleared.
`timescale 1ns / 1ps

module bounded_array_deque #(
    parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [bdq_pkg::CMD_W-1:0]    cmd,
    input  logic [bdq_pkg::VALUE_W-1:0]  value,
    input  logic [bdq_pkg::POS_W-1:0]    position,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [bdq_pkg::VALUE_W-1:0]  read_value,
    output logic [bdq_pkg::COUNT_W-1:0]  entry_count,
    output logic                         is_empty,
    output logic [bdq_pkg::STATUS_W-1:0] status
);

    import bdq_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0]   ONE   = CW'(1);
    localparam logic [CW-1:0]   FULL  = CW'(DEPTH);
    localparam logic [CMPW-1:0] DEP_W = CMPW'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_INS_WR,
        S_READ,
        S_RD_CAP,
        S_RESULT
    } state_t;

    state_t                state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [STATUS_W-1:0]   st_reg, st_next;
    logic [VALUE_W-1:0]    rd_reg, rd_next;
    logic [DATA_WIDTH-1:0] val_reg, val_next;
    logic [AW-1:0]         addr_reg, addr_next;
    logic                  ins_reg, ins_next;
    logic                  out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]    read_value_reg, read_value_next;
    logic [COUNT_W-1:0]    entry_count_reg, entry_count_next;
    logic                  is_empty_reg, is_empty_next;
    logic [STATUS_W-1:0]   status_reg, status_next;

    logic                  accept;
    logic [CMPW-1:0]       pos_w;
    logic [CMPW-1:0]       cnt_w;
    logic [CW-1:0]         pos_c;
    logic [DATA_WIDTH-1:0] val_in;

    walk_cmd_t             walk_cmd;
    logic [CW-1:0]         walk_start;
    logic [CW-1:0]         walk_len;
    logic [DATA_WIDTH-1:0] walk_fill;
    logic                  walk_busy;
    logic                  walk_rd_en;
    logic [AW-1:0]         walk_rd_addr;
    logic                  walk_wr_en;
    logic [AW-1:0]         walk_wr_addr;
    logic [DATA_WIDTH-1:0] walk_wr_data;

    logic                  ram_rd_en;
    logic [AW-1:0]         ram_rd_addr;
    logic [DATA_WIDTH-1:0] ram_rd_data;
    logic                  ram_wr_en;
    logic [AW-1:0]         ram_wr_addr;
    logic [DATA_WIDTH-1:0] ram_wr_data;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && (state_reg == S_IDLE);
    assign pos_w    = CMPW'(position);
    assign cnt_w    = CMPW'(count_reg);
    assign pos_c    = CW'(pos_w);
    assign val_in   = DATA_WIDTH'(value);

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        st_next          = st_reg;
        rd_next          = rd_reg;
        val_next         = val_reg;
        addr_next        = addr_reg;
        ins_next         = ins_reg;
        out_valid_next   = out_valid_reg;
        read_value_next  = read_value_reg;
        entry_count_next = entry_count_reg;
        is_empty_next    = is_empty_reg;
        status_next      = status_reg;
        walk_cmd.go      = 1'b0;
        walk_cmd.mode    = WALK_FILL;
        walk_start       = '0;
        walk_len         = '0;
        walk_fill        = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    st_next    = ST_OK;
                    rd_next    = '0;
                    val_next   = val_in;
                    ins_next   = 1'b0;
                    state_next = S_RESULT;
                    case (cmd)
                        CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT:
                        begin
                            if (count_reg == FULL)
                            begin
                                st_next = ST_FULL;
                            end
                            else if (cmd == CMD_INSERT && pos_w > cnt_w)
                            begin
                                st_next = ST_RANGE;
                            end
                            else
                            begin
                                // open a gap at the target slot, then drop the word in
                                if (cmd == CMD_PUSH_FRONT)
                                begin
                                    addr_next = '0;
                                    walk_len  = count_reg;
                                end
                                else if (cmd == CMD_PUSH_BACK)
                                begin
                                    addr_next = count_reg[AW-1:0];
                                    walk_len  = '0;
                                end
                                else
                                begin
                                    addr_next = pos_c[AW-1:0];
                                    walk_len  = count_reg - pos_c;
                                end
                                walk_cmd.go   = 1'b1;
                                walk_cmd.mode = WALK_UP;
                                walk_start    = count_reg - ONE;
                                ins_next      = 1'b1;
                                count_next    = count_reg + ONE;
                                state_next    = S_WALK;
                            end
                        end
                        CMD_POP_FRONT:
                        begin
                            if (count_reg == '0)
                            begin
                                st_next = ST_EMPTY;
                            end
                            else
                            begin
                                walk_cmd.go   = 1'b1;
                                walk_cmd.mode = WALK_DOWN;
                                walk_start    = ONE;
                                walk_len      = count_reg - ONE;
                                count_next    = count_reg - ONE;
                                state_next    = S_WALK;
                            end
                        end
                        CMD_POP_BACK:
                        begin
                            if (count_reg == '0)
                            begin
                                st_next = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - ONE;
                            end
                        end
                        CMD_ERASE:
                        begin
                            if (count_reg == '0)
                            begin
                                st_next = ST_EMPTY;
                            end
                            else if (pos_w >= cnt_w)
                            begin
                                st_next = ST_RANGE;
                            end
                            else
                            begin
                                walk_cmd.go   = 1'b1;
                                walk_cmd.mode = WALK_DOWN;
                                walk_start    = pos_c + ONE;
                                walk_len      = count_reg - ONE - pos_c;
                                count_next    = count_reg - ONE;
                                state_next    = S_WALK;
                            end
                        end
                        CMD_READ_AT:
                        begin
                            if (pos_w >= cnt_w)
                            begin
                                st_next = ST_RANGE;
                            end
                            else
                            begin
                                addr_next  = pos_c[AW-1:0];
                                state_next = S_READ;
                            end
                        end
                        CMD_FRONT, CMD_BACK:
                        begin
                            if (count_reg == '0)
                            begin
                                st_next = ST_EMPTY;
                            end
                            else
                            begin
                                if (cmd == CMD_FRONT)
                                begin
                                    addr_next = '0;
                                end
                                else
                                begin
                                    addr_next = AW'(count_reg - ONE);
                                end
                                state_next = S_READ;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        CMD_RESIZE:
                        begin
                            if (pos_w > DEP_W)
                            begin
                                st_next = ST_RANGE;
                            end
                            else
                            begin
                                // zero only the slots newly brought into use
                                if (pos_w > cnt_w)
                                begin
                                    walk_cmd.go   = 1'b1;
                                    walk_cmd.mode = WALK_FILL;
                                    walk_start    = count_reg;
                                    walk_len      = pos_c - count_reg;
                                    state_next    = S_WALK;
                                end
                                count_next = pos_c;
                            end
                        end
                        CMD_ASSIGN:
                        begin
                            if (pos_w > DEP_W)
                            begin
                                st_next = ST_RANGE;
                            end
                            else
                            begin
                                walk_cmd.go   = 1'b1;
                                walk_cmd.mode = WALK_FILL;
                                walk_start    = '0;
                                walk_len      = pos_c;
                                walk_fill     = val_in;
                                count_next    = pos_c;
                                state_next    = S_WALK;
                            end
                        end
                        default:
                        begin
                            st_next = ST_OK;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                if (!walk_busy)
                begin
                    state_next = ins_reg ? S_INS_WR : S_RESULT;
                end
            end
            S_INS_WR:
            begin
                state_next = S_RESULT;
            end
            S_READ:
            begin
                state_next = S_RD_CAP;
            end
            S_RD_CAP:
            begin
                rd_next    = VALUE_W'(ram_rd_data);
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    read_value_next  = rd_reg;
                    entry_count_next = COUNT_W'(count_reg);
                    is_empty_next    = (count_reg == '0);
                    status_next      = st_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            st_reg          <= ST_OK;
            rd_reg          <= '0;
            val_reg         <= '0;
            addr_reg        <= '0;
            ins_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
            read_value_reg  <= '0;
            entry_count_reg <= '0;
            is_empty_reg    <= 1'b1;
            status_reg      <= ST_OK;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            st_reg          <= st_next;
            rd_reg          <= rd_next;
            val_reg         <= val_next;
            addr_reg        <= addr_next;
            ins_reg         <= ins_next;
            out_valid_reg   <= out_valid_next;
            read_value_reg  <= read_value_next;
            entry_count_reg <= entry_count_next;
            is_empty_reg    <= is_empty_next;
            status_reg      <= status_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_value  = read_value_reg;
    assign entry_count = entry_count_reg;
    assign is_empty    = is_empty_reg;
    assign status      = status_reg;

    assign ram_rd_en   = walk_busy ? walk_rd_en : (state_reg == S_READ);
    assign ram_rd_addr = walk_busy ? walk_rd_addr : addr_reg;
    assign ram_wr_en   = walk_wr_en || (state_reg == S_INS_WR);
    assign ram_wr_addr = (state_reg == S_INS_WR) ? addr_reg : walk_wr_addr;
    assign ram_wr_data = (state_reg == S_INS_WR) ? val_reg : walk_wr_data;

    bdq_walker #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .walk_cmd   (walk_cmd),
        .start_addr (walk_start),
        .length     (walk_len),
        .fill_data  (walk_fill),
        .busy       (walk_busy),
        .rd_en      (walk_rd_en),
        .rd_addr    (walk_rd_addr),
        .rd_data    (ram_rd_data),
        .wr_en      (walk_wr_en),
        .wr_addr    (walk_wr_addr),
        .wr_data    (walk_wr_data)
    );

    bdq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_entries (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE)
        else $error("accepted word did not start a command");

    a_walk_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        walk_busy |-> state_reg == S_WALK)
        else $error("walker busy outside the walk state");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_INS_WR |-> count_reg != '0 && count_reg <= FULL)
        else $error("count out of bounds at insert");

    a_result_loads: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RESULT && (!out_valid_reg || !out_stall)
        |=> out_valid_reg && state_reg == S_IDLE)
        else $error("result not registered");

endmodule

FILE: sv/bdq_ram.sv
`timescale 1ns / 1ps

module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/bdq_walker.sv
`timescale 1ns / 1ps

module bdq_walker #(
    parameter int DEPTH      = 128,
    parameter int DATA_WIDTH = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bdq_pkg::walk_cmd_t         walk_cmd,
    input  logic [$clog2(DEPTH+1)-1:0] start_addr,
    input  logic [$clog2(DEPTH+1)-1:0] length,
    input  logic [DATA_WIDTH-1:0]      fill_data,
    output logic                       busy,
    output logic                       rd_en,
    output logic [$clog2(DEPTH)-1:0]   rd_addr,
    input  logic [DATA_WIDTH-1:0]      rd_data,
    output logic                       wr_en,
    output logic [$clog2(DEPTH)-1:0]   wr_addr,
    output logic [DATA_WIDTH-1:0]      wr_data
);

    import bdq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] ONE      = CW'(1);
    localparam logic [CW-1:0] MINUS_ONE = {CW{1'b1}};

    walk_mode_t            mode_reg, mode_next;
    logic [CW-1:0]         src_reg, src_next;
    logic [CW-1:0]         dst_reg, dst_next;
    logic [CW-1:0]         left_reg, left_next;
    logic [DATA_WIDTH-1:0] fill_reg, fill_next;
    logic                  pend_reg, pend_next;
    logic                  busy_reg, busy_next;
    logic [CW-1:0]         src_step;
    logic [CW-1:0]         src_back;

    // shared stepper: walk the source pointer one slot per cycle
    assign src_step = src_reg + ((mode_reg == WALK_UP) ? MINUS_ONE : ONE);
    assign src_back = src_reg + ((mode_reg == WALK_UP) ? ONE : MINUS_ONE);

    always_comb
    begin
        mode_next = mode_reg;
        src_next  = src_reg;
        dst_next  = dst_reg;
        left_next = left_reg;
        fill_next = fill_reg;
        pend_next = pend_reg;
        busy_next = busy_reg;
        rd_en     = 1'b0;
        rd_addr   = src_reg[AW-1:0];
        wr_en     = 1'b0;
        wr_addr   = dst_reg[AW-1:0];
        wr_data   = rd_data;
        if (walk_cmd.go)
        begin
            mode_next = walk_cmd.mode;
            src_next  = start_addr;
            left_next = length;
            fill_next = fill_data;
            pend_next = 1'b0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (mode_reg == WALK_FILL)
            begin
                wr_addr = src_reg[AW-1:0];
                wr_data = fill_reg;
                if (left_reg != '0)
                begin
                    wr_en     = 1'b1;
                    src_next  = src_step;
                    left_next = left_reg - ONE;
                end
                else
                begin
                    busy_next = 1'b0;
                end
            end
            else
            begin
                // write back the word read last cycle, one slot over
                wr_en = pend_reg;
                if (left_reg != '0)
                begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    dst_next  = src_back;
                    src_next  = src_step;
                    left_next = left_reg - ONE;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        busy_next = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pend_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        src_reg  <= src_next;
        dst_reg  <= dst_next;
        left_reg <= left_next;
        fill_reg <= fill_next;
    end

    assign busy = busy_reg;

    a_pend_only_shift: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> busy_reg && mode_reg != WALK_FILL)
        else $error("walker write pending outside a shift");

    a_go_makes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        walk_cmd.go |=> busy_reg)
        else $error("walker not busy after start");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> !wr_en && !rd_en)
        else $error("walker drives memory while idle");

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import bdq_pkg::*;

    localparam int DEQUE_DEPTH  = DEPTH_DEF;
    localparam int CMD_CODES    = 1 << CMD_W;
    localparam int RANDOM_WORDS = 420;
    localparam int STALL_LIMIT  = 16 * DEQUE_DEPTH + 256;

    typedef struct packed {
        logic [CMD_W-1:0]   op;
        logic [VALUE_W-1:0] data;
        logic [POS_W-1:0]   pos;
    } deque_word_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  rd;
        logic [COUNT_W-1:0]  cnt;
        logic                empty;
        logic [STATUS_W-1:0] st;
    } deque_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [CMD_W-1:0]      cmd = '0;
    logic [VALUE_W-1:0]    value = '0;
    logic [POS_W-1:0]      position = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [VALUE_W-1:0]    read_value;
    logic [COUNT_W-1:0]    entry_count;
    logic                  is_empty;
    logic [STATUS_W-1:0]   status;

    bounded_array_deque #(
        .DEPTH      (DEQUE_DEPTH),
        .DATA_WIDTH (DATA_WIDTH_DEF)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .value       (value),
        .position    (position),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_value  (read_value),
        .entry_count (entry_count),
        .is_empty    (is_empty),
        .status      (status)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    deque_word_t   pending_words[$];
    deque_result_t expected_results[$];
    deque_word_t   word_now;

    logic [VALUE_W-1:0] shadow_mem [DEQUE_DEPTH];
    int shadow_count = 0;
    int plan_count = 0;
    int words_total = 0;
    int words_sent = 0;
    int mismatches = 0;
    int quiet_cycles = 0;
    bit in_taken = 1'b0;
    bit out_taken = 1'b0;

    // keep both sides busy for a stretch in the middle of the run
    wire calm = (words_sent >= 150) && (words_sent < 250);

    function automatic bit take_break();
        return !calm && ($urandom_range(0, 99) < 24);
    endfunction

    // deque behaviour: update the shadow copy and return the result word
    function automatic deque_result_t apply_command(deque_word_t w);
        deque_result_t r;
        int at;
        int i;
        r = '0;
        r.st = ST_OK;
        case (w.op)
            CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT:
            begin
                if (shadow_count >= DEQUE_DEPTH)
                begin
                    r.st = ST_FULL;
                end
                else
                begin
                    if (w.op == CMD_PUSH_FRONT)
                        at = 0;
                    else if (w.op == CMD_PUSH_BACK)
                        at = shadow_count;
                    else
                        at = int'(w.pos);
                    if (at > shadow_count)
                    begin
                        r.st = ST_RANGE;
                    end
                    else
                    begin
                        for (i = shadow_count; i > at; i--)
                            shadow_mem[i] = shadow_mem[i-1];
                        shadow_mem[at] = w.data;
                        shadow_count++;
                    end
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK:
            begin
                if (shadow_count == 0)
                begin
                    r.st = ST_EMPTY;
                end
                else
                begin
                    if (w.op == CMD_POP_FRONT)
                        for (i = 0; i + 1 < shadow_count; i++)
                            shadow_mem[i] = shadow_mem[i+1];
                    shadow_count--;
                end
            end
            CMD_ERASE:
            begin
                if (shadow_count == 0)
                    r.st = ST_EMPTY;
                else if (int'(w.pos) >= shadow_count)
                    r.st = ST_RANGE;
                else
                begin
                    for (i = int'(w.pos); i + 1 < shadow_count; i++)
                        shadow_mem[i] = shadow_mem[i+1];
                    shadow_count--;
                end
            end
            CMD_READ_AT:
            begin
                if (int'(w.pos) >= shadow_count)
                    r.st = ST_RANGE;
                else
                    r.rd = shadow_mem[w.pos];
            end
            CMD_FRONT, CMD_BACK:
            begin
                if (shadow_count == 0)
                    r.st = ST_EMPTY;
                else if (w.op == CMD_FRONT)
                    r.rd = shadow_mem[0];
                else
                    r.rd = shadow_mem[shadow_count-1];
            end
            CMD_CLEAR:
            begin
                shadow_count = 0;
            end
            CMD_RESIZE, CMD_ASSIGN:
            begin
                if (int'(w.pos) > DEQUE_DEPTH)
                    r.st = ST_RANGE;
                else
                begin
                    if (w.op == CMD_RESIZE)
                        for (i = shadow_count; i < int'(w.pos); i++)
                            shadow_mem[i] = '0;
                    else
                        for (i = 0; i < int'(w.pos); i++)
                            shadow_mem[i] = w.data;
                    shadow_count = int'(w.pos);
                end
            end
            default:
            begin
            end
        endcase
        r.cnt = shadow_count[COUNT_W-1:0];
        r.empty = (shadow_count == 0);
        return r;
    endfunction

    // rough entry count at generation time, used only to aim positions
    function automatic int size_after(deque_word_t w, int n);
        case (w.op)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: return (n < DEQUE_DEPTH) ? n + 1 : n;
            CMD_INSERT: return (n < DEQUE_DEPTH && int'(w.pos) <= n) ? n + 1 : n;
            CMD_POP_FRONT, CMD_POP_BACK: return (n > 0) ? n - 1 : n;
            CMD_ERASE: return (int'(w.pos) < n) ? n - 1 : n;
            CMD_CLEAR: return 0;
            CMD_RESIZE, CMD_ASSIGN: return (int'(w.pos) <= DEQUE_DEPTH) ? int'(w.pos) : n;
            default: return n;
        endcase
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom;
    endfunction

    task automatic queue_word(input logic [CMD_W-1:0] op, input logic [VALUE_W-1:0] data,
                              input int pos);
        deque_word_t w;
        w.op = op;
        w.data = data;
        w.pos = pos[POS_W-1:0];
        pending_words.insert(pending_words.size(), w);
        plan_count = size_after(w, plan_count);
    endtask

    task automatic report_mismatch(input string field, input logic [VALUE_W-1:0] got,
                                   input logic [VALUE_W-1:0] want);
        $display("%0t: mismatch on %s: got %h, want %h", $time, field, got, want);
        mismatches++;
    endtask

    // drive a word at the falling edge; hold it while stalled
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (pending_words.size() > 0 && !take_break())
                begin
                    word_now = pending_words[0];
                    pending_words.delete(0);
                    cmd <= word_now.op;
                    value <= word_now.data;
                    position <= word_now.pos;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= take_break();
        end
    end

    always @(posedge clk)
    begin
        deque_result_t want;
        in_taken = rst_n && in_valid && !in_stall;
        out_taken = rst_n && out_valid && !out_stall;
        if (out_taken)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected result word", read_value, '0);
            end
            else
            begin
                want = expected_results[0];
                expected_results.delete(0);
                if (read_value !== want.rd)
                    report_mismatch("read_value", read_value, want.rd);
                if (entry_count !== want.cnt)
                    report_mismatch("entry_count", VALUE_W'(entry_count),
                                    VALUE_W'(want.cnt));
                if (is_empty !== want.empty)
                    report_mismatch("is_empty", VALUE_W'(is_empty), VALUE_W'(want.empty));
                if (status !== want.st)
                    report_mismatch("status", VALUE_W'(status), VALUE_W'(want.st));
            end
        end
        if (in_taken)
        begin
            expected_results.insert(expected_results.size(),
                                    apply_command({cmd, value, position}));
            words_sent++;
        end
        if (in_taken || out_taken)
            quiet_cycles = 0;
        else if (rst_n)
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        int k;
        int n;
        int pick;
        int pos;
        int r;
        logic [CMD_W-1:0] op;

        // underflow on every removal and read while empty
        queue_word(CMD_POP_FRONT, '0, 0);
        queue_word(CMD_POP_BACK, '0, 0);
        queue_word(CMD_FRONT, '0, 0);
        queue_word(CMD_BACK, '0, 0);
        queue_word(CMD_ERASE, '0, 0);
        queue_word(CMD_READ_AT, '0, 0);
        queue_word(CMD_PUSH_FRONT, '1, 0);
        queue_word(CMD_PUSH_BACK, '0, 0);
        queue_word(CMD_INSERT, 32'h0bad_f00d, 3);
        // insert at the count appends
        queue_word(CMD_INSERT, 32'ha5a5_5a5a, 2);
        queue_word(CMD_INSERT, 32'h1234_5678, 0);
        queue_word(CMD_READ_AT, '0, 255);
        queue_word(CMD_ERASE, '0, 4);
        queue_word(CMD_ERASE, '0, 1);
        queue_word(CMD_FRONT, '0, 0);
        queue_word(CMD_BACK, '0, 0);
        queue_word(CMD_RESIZE, '0, DEQUE_DEPTH + 1);
        queue_word(CMD_ASSIGN, '1, 255);
        // grow to full: new slots read back as zero
        queue_word(CMD_RESIZE, '0, DEQUE_DEPTH);
        queue_word(CMD_PUSH_BACK, '1, 0);
        queue_word(CMD_PUSH_FRONT, '1, 0);
        queue_word(CMD_INSERT, '1, 0);
        queue_word(CMD_READ_AT, '0, DEQUE_DEPTH - 1);
        queue_word(CMD_ASSIGN, 32'h8000_0001, DEQUE_DEPTH);
        queue_word(CMD_BACK, '0, 0);
        queue_word(CMD_ASSIGN, 32'h7fff_fffe, 3);
        queue_word(CMD_RESIZE, '0, 6);
        queue_word(CMD_READ_AT, '0, 5);
        queue_word(CMD_W'(CMD_ASSIGN + 1), '1, 255);
        queue_word(CMD_W'(CMD_CODES - 1), '0, 0);
        queue_word(CMD_CLEAR, '1, 255);

        for (k = 0; k < RANDOM_WORDS; k++)
        begin
            n = plan_count;
            pick = $urandom_range(0, 99);
            pos = $urandom_range(0, 255);
            if (pick < 12)
                op = CMD_PUSH_FRONT;
            else if (pick < 26)
                op = CMD_PUSH_BACK;
            else if (pick < 34)
                op = CMD_POP_FRONT;
            else if (pick < 42)
                op = CMD_POP_BACK;
            else if (pick < 54)
            begin
                op = CMD_INSERT;
                if ($urandom_range(0, 9) != 0)
                    pos = $urandom_range(0, n);
            end
            else if (pick < 74)
            begin
                op = (pick < 64) ? CMD_ERASE : CMD_READ_AT;
                if (n > 0 && $urandom_range(0, 9) != 0)
                    pos = $urandom_range(0, n - 1);
            end
            else if (pick < 79)
                op = CMD_FRONT;
            else if (pick < 84)
                op = CMD_BACK;
            else if (pick < 87)
                op = CMD_CLEAR;
            else if (pick < 97)
            begin
                op = (pick < 92) ? CMD_RESIZE : CMD_ASSIGN;
                r = $urandom_range(0, 19);
                if (r < 12)
                    pos = $urandom_range(0, (n + 8 > DEQUE_DEPTH) ? DEQUE_DEPTH : n + 8);
                else if (r < 17)
                    pos = $urandom_range(DEQUE_DEPTH - 8, DEQUE_DEPTH);
            end
            else
                op = CMD_W'($urandom_range(CMD_ASSIGN + 1, CMD_CODES - 1));
            queue_word(op, pick_value(), pos);
        end
        words_total = pending_words.size();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (words_sent < words_total)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DEQUE_DEPTH + 8) @(posedge clk);

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
